// ===== rtl/core/pae_pkg.sv =====
// Shared types, constants and codes for the percentile auto-exposure core.
`timescale 1ns / 1ps
package pae_pkg;

  // Geometry and limits
  localparam int unsigned MaxWidth    = 4096;
  localparam int unsigned HistBins    = 32;
  localparam int unsigned BinW        = 5;
  localparam int unsigned CountW      = 19;
  localparam int unsigned CumW        = CountW + BinW;
  localparam int unsigned MaxSteps    = 3;
  localparam int unsigned DivW        = 26;
  localparam int unsigned DivisorW    = 13;

  localparam logic [CountW-1:0] CountMax      = 19'h7FFFF;
  localparam logic [12:0]       ExposureReset = 13'h0940;
  localparam logic [7:0]        TargetDefault = 8'd95;
  localparam logic [7:0]        TargetHigh    = 8'd250;
  localparam logic [7:0]        Pedestal      = 8'd16;
  localparam logic [7:0]        DeadBand      = 8'd8;
  localparam logic [9:0]        RatioMin      = 10'd85;
  localparam logic [9:0]        RatioMax      = 10'd768;
  localparam logic [12:0]       ExposureMin   = 13'd8;
  localparam logic [12:0]       ExposureMax   = 13'd5000;
  localparam logic [9:0]        GainCodeMax   = 10'd960;
  localparam logic [12:0]       GainQ8Unity   = 13'd256;
  localparam logic [12:0]       GainQ8Max     = 13'd4096;
  localparam logic [10:0]       GainScale     = 11'd1024;
  localparam logic [DivW-1:0]   GainScaleQ8   = 26'd262144;

  // Configuration register indexes
  localparam logic [1:0] RegAeEnable      = 2'd0;
  localparam logic [1:0] RegTargetLevel   = 2'd1;
  localparam logic [1:0] RegFrameWidth    = 2'd2;
  localparam logic [1:0] RegPreviewActive = 2'd3;

  typedef enum logic [1:0] {
    OP_PIXEL   = 2'd0,
    OP_EOF     = 2'd1,
    OP_MEASURE = 2'd2,
    OP_REINIT  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_DISABLED   = 3'd1,
    ST_STEP_LIMIT = 3'd2,
    ST_DEADBAND   = 3'd3,
    ST_NEGLIGIBLE = 3'd4,
    ST_EMPTY      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_STEP   = 2'd0,
    CMD_EMPTY  = 2'd1,
    CMD_REINIT = 2'd2
  } cmd_kind_e;

  typedef enum logic {
    F_RUN  = 1'b0,
    F_SCAN = 1'b1
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE  = 4'd0,
    B_RATIO = 4'd1,
    B_GAIN  = 4'd2,
    B_MUL1  = 4'd3,
    B_MUL2  = 4'd4,
    B_DGO   = 4'd5,
    B_DG    = 4'd6,
    B_DC    = 4'd7,
    B_DEC   = 4'd8
  } back_state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pixel_luma;
    logic [7:0] measured_level;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  level_used;
    logic [12:0] exposure_value;
    logic [9:0]  gain_value;
    logic        exposure_written;
    logic        gain_written;
  } out_beat_t;

  typedef struct packed {
    logic        ae_enable;
    logic [7:0]  target_level;
    logic [12:0] frame_width;
    logic        preview_active;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] level;
  } cmd_t;

endpackage

// ===== rtl/core/pae_front.sv =====
// Front end: pixel subsampling into the histogram and the percentile scan.
`timescale 1ns / 1ps
module pae_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pae_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pae_pkg::in_beat_t in_beat_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output pae_pkg::cmd_t     q_cmd_o
);
  import pae_pkg::*;

  front_state_e      state_q, state_d;
  logic [CountW-1:0] hist_q [HistBins];
  logic [CountW-1:0] hist_d [HistBins];
  logic [CountW-1:0] count_q, count_d;
  logic [11:0]       col_q, col_d;
  logic [2:0]        phase_q, phase_d;
  logic [BinW-1:0]   idx_q, idx_d;
  logic [CumW-1:0]   cum_q, cum_d;
  logic [CumW-1:0]   cum_sum;
  logic [CountW-1:0] limit_q, limit_d;
  logic              found_q, found_d;
  logic [7:0]        lvl_q, lvl_d;
  logic [12:0]       width;
  logic [12:0]       col_inc;
  logic              accept;
  logic              sample;
  logic [BinW-1:0]   bin;
  logic [CountW+1:0] count3;

  // Clamp the row width to 1..MaxWidth
  always_comb begin
    width = cfg_i.frame_width;
    if (width == 13'd0) width = 13'd1;
    if (width > 13'(MaxWidth)) width = 13'(MaxWidth);
  end

  assign in_stall_o = (state_q == F_SCAN)
                    || (opcode_e'(in_beat_i.opcode) != OP_PIXEL && q_full_i);
  assign accept  = in_valid_i && !in_stall_o;
  assign col_inc = {1'b0, col_q} + 13'd1;
  assign sample  = (phase_q == 3'd0) && (col_q[2:0] == 3'd0);
  assign bin     = in_beat_i.pixel_luma[7:3];
  assign cum_sum = cum_q + CumW'(hist_q[0]);
  assign count3  = {2'b0, count_q} + {1'b0, count_q, 1'b0};

  always_comb begin
    state_d  = state_q;
    hist_d   = hist_q;
    count_d  = count_q;
    col_d    = col_q;
    phase_d  = phase_q;
    idx_d    = idx_q;
    cum_d    = cum_q;
    limit_d  = limit_q;
    found_d  = found_q;
    lvl_d    = lvl_q;
    q_push_o = 1'b0;
    q_cmd_o  = '{kind: CMD_STEP, level: 8'd0};
    case (state_q)
      F_RUN: begin
        if (accept) begin
          case (opcode_e'(in_beat_i.opcode))
            OP_PIXEL: begin
              if (sample) begin
                for (int i = 0; i < HistBins; i++) begin
                  if (bin == BinW'(i) && hist_q[i] != CountMax) hist_d[i] = hist_q[i] + 1'b1;
                end
                if (count_q != CountMax) count_d = count_q + 1'b1;
              end
              if (col_inc >= width) begin
                col_d   = '0;
                phase_d = phase_q + 3'd1;
              end else begin
                col_d = col_inc[11:0];
              end
            end
            OP_EOF: begin
              count_d = '0;
              col_d   = '0;
              phase_d = '0;
              if (count_q == '0) begin
                q_push_o = 1'b1;
                q_cmd_o  = '{kind: CMD_EMPTY, level: 8'd0};
              end else begin
                state_d = F_SCAN;
                idx_d   = '0;
                cum_d   = '0;
                found_d = 1'b0;
                lvl_d   = 8'd255;
                limit_d = count3[CountW+1:2];
              end
            end
            OP_MEASURE: begin
              q_push_o = 1'b1;
              q_cmd_o  = '{kind: CMD_STEP, level: in_beat_i.measured_level};
            end
            default: begin
              q_push_o = 1'b1;
              q_cmd_o  = '{kind: CMD_REINIT, level: 8'd0};
            end
          endcase
        end
      end
      F_SCAN: begin
        // Walk bin 0 out of the shift line; the line empties as it goes
        for (int i = 0; i < HistBins - 1; i++) hist_d[i] = hist_q[i+1];
        hist_d[HistBins-1] = '0;
        cum_d = cum_sum;
        idx_d = idx_q + 1'b1;
        if (!found_q && cum_sum >= CumW'(limit_q)) begin
          found_d = 1'b1;
          lvl_d   = {idx_q, 3'd4};
        end
        if (idx_q == BinW'(HistBins - 1)) begin
          state_d  = F_RUN;
          q_push_o = 1'b1;
          q_cmd_o  = '{kind: CMD_STEP,
                       level: (!found_q && cum_sum >= CumW'(limit_q)) ? {idx_q, 3'd4} : lvl_q};
        end
      end
      default: state_d = F_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_RUN;
      count_q <= '0;
      col_q   <= '0;
      phase_q <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
      for (int i = 0; i < HistBins; i++) hist_q[i] <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      col_q   <= col_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      hist_q  <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cum_q   <= cum_d;
    limit_q <= limit_d;
    lvl_q   <= lvl_d;
  end

endmodule

// ===== rtl/core/pae_cmdq.sv =====
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
module pae_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pae_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          avail_o,
  output pae_pkg::cmd_t cmd_o
);
  import pae_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== rtl/core/pae_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pae_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pae_pkg::DivW-1:0]     dividend_i,
  input  logic [pae_pkg::DivisorW-1:0] divisor_i,
  output logic                         done_o,
  output logic [pae_pkg::DivW-1:0]     quot_o
);
  import pae_pkg::*;

  logic                busy_q, done_q;
  logic [4:0]          cnt_q;
  logic [DivisorW-1:0] dvs_q;
  logic [DivisorW-1:0] rem_q;
  logic [DivW-1:0]     quo_q;
  logic [DivisorW:0]   rem_sh;
  logic                ge;

  assign rem_sh = {rem_q, quo_q[DivW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? DivisorW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DivisorW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/pae_back.sv =====
// Back end: one damped exposure step per step command, with the result register.
`timescale 1ns / 1ps
module pae_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pae_pkg::cfg_t      cfg_i,
  input  logic               q_avail_i,
  input  pae_pkg::cmd_t      q_cmd_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pae_pkg::out_beat_t out_beat_o
);
  import pae_pkg::*;

  back_state_e         state_q, state_d;
  logic [12:0]         exp_q, exp_d;
  logic [9:0]          gain_q, gain_d;
  logic [1:0]          steps_q, steps_d;
  logic [7:0]          level_q, level_d;
  logic [9:0]          ratio_q, ratio_d;
  logic [12:0]         gq8_q, gq8_d;
  logic [16:0]         plines_q, plines_d;
  logic [17:0]         newp_q, newp_d;
  logic [12:0]         newexp_q, newexp_d;
  logic [9:0]          code_q, code_d;
  logic                ovalid_q, ovalid_d;
  out_beat_t           obeat_q, obeat_d;

  logic                slot_free;
  logic [7:0]          target, t_eff, m_eff, lvl;
  logic                in_deadband;
  logic                div_start, div_done;
  logic [DivW-1:0]     div_dividend, div_quot;
  logic [DivisorW-1:0] div_divisor;
  logic [12:0]         gq_clamp;
  logic [25:0]         prod1;
  logic [26:0]         prod2;
  logic [18:0]         newp_raw;
  logic [12:0]         exp_delta;
  logic [9:0]          gain_delta;
  logic [17:0]         delta20;
  logic [10:0]         code_raw;

  pae_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign slot_free = !ovalid_q || !out_stall_i;
  assign lvl       = q_cmd_i.level;

  // Target, pedestal-corrected levels and the deadband window
  always_comb begin
    target = cfg_i.target_level;
    if (target == 8'd0 || target > TargetHigh) target = TargetDefault;
    t_eff = (target > Pedestal) ? target - Pedestal : 8'd2;
    m_eff = (lvl > Pedestal + 8'd2) ? lvl - Pedestal : 8'd2;
    in_deadband = ({1'b0, lvl} + {1'b0, DeadBand} >= {1'b0, target})
               && ({1'b0, lvl} <= {1'b0, target} + {1'b0, DeadBand});
  end

  // Gain Q8 clamp feeding the code division
  always_comb begin
    gq_clamp = 13'(div_quot);
    if (div_quot < DivW'(GainQ8Unity)) gq_clamp = GainQ8Unity;
    if (div_quot > DivW'(GainQ8Max)) gq_clamp = GainQ8Max;
  end

  // Divider operands follow the sequencer state
  always_comb begin
    case (state_q)
      B_IDLE: begin
        div_dividend = DivW'({t_eff, 8'd0});
        div_divisor  = DivisorW'(m_eff);
      end
      B_RATIO: begin
        div_dividend = GainScaleQ8;
        div_divisor  = DivisorW'(GainScale - {1'b0, gain_q});
      end
      B_DGO: begin
        div_dividend = {newp_q, 8'd0};
        div_divisor  = newexp_q;
      end
      default: begin
        div_dividend = GainScaleQ8;
        div_divisor  = gq_clamp;
      end
    endcase
  end

  assign prod1    = exp_q * gq8_q;
  assign prod2    = plines_q * ratio_q;
  assign newp_raw = prod2[26:8];
  assign code_raw = GainScale - 11'(div_quot);
  assign exp_delta  = (newexp_q > exp_q) ? newexp_q - exp_q : exp_q - newexp_q;
  assign gain_delta = (code_q > gain_q) ? code_q - gain_q : gain_q - code_q;
  assign delta20    = (18'(exp_delta) + 18'd1) * 18'd20;

  always_comb begin
    state_d   = state_q;
    exp_d     = exp_q;
    gain_d    = gain_q;
    steps_d   = steps_q;
    level_d   = level_q;
    ratio_d   = ratio_q;
    gq8_d     = gq8_q;
    plines_d  = plines_q;
    newp_d    = newp_q;
    newexp_d  = newexp_q;
    code_d    = code_q;
    ovalid_d  = ovalid_q && out_stall_i;
    obeat_d   = obeat_q;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (q_avail_i) begin
          case (q_cmd_i.kind)
            CMD_REINIT: begin
              q_pop_o = 1'b1;
              exp_d   = ExposureReset;
              gain_d  = '0;
              steps_d = '0;
            end
            CMD_EMPTY: begin
              if (slot_free) begin
                q_pop_o  = 1'b1;
                ovalid_d = 1'b1;
                obeat_d  = '{ST_EMPTY, 8'd0, exp_q, gain_q, 1'b0, 1'b0};
              end
            end
            default: begin
              if (slot_free) begin
                q_pop_o = 1'b1;
                level_d = lvl;
                if (!cfg_i.ae_enable) begin
                  ovalid_d = 1'b1;
                  obeat_d  = '{ST_DISABLED, lvl, exp_q, gain_q, 1'b0, 1'b0};
                end else if (steps_q >= 2'(MaxSteps) && !cfg_i.preview_active) begin
                  ovalid_d = 1'b1;
                  obeat_d  = '{ST_STEP_LIMIT, lvl, exp_q, gain_q, 1'b0, 1'b0};
                end else if (in_deadband) begin
                  ovalid_d = 1'b1;
                  obeat_d  = '{ST_DEADBAND, lvl, exp_q, gain_q, 1'b0, 1'b0};
                end else begin
                  div_start = 1'b1;
                  state_d   = B_RATIO;
                end
              end
            end
          endcase
        end
      end
      B_RATIO: begin
        if (div_done) begin
          ratio_d = 10'(div_quot);
          if (div_quot < DivW'(RatioMin)) ratio_d = RatioMin;
          if (div_quot > DivW'(RatioMax)) ratio_d = RatioMax;
          div_start = 1'b1;
          state_d   = B_GAIN;
        end
      end
      B_GAIN: begin
        if (div_done) begin
          gq8_d   = 13'(div_quot);
          state_d = B_MUL1;
        end
      end
      B_MUL1: begin
        plines_d = prod1[24:8];
        state_d  = B_MUL2;
      end
      B_MUL2: begin
        newp_d = (newp_raw < 19'(ExposureMin)) ? 18'(ExposureMin) : newp_raw[17:0];
        newexp_d = (newp_raw > 19'(ExposureMax)) ? ExposureMax
                 : (newp_raw < 19'(ExposureMin)) ? ExposureMin : newp_raw[12:0];
        state_d = B_DGO;
      end
      B_DGO: begin
        div_start = 1'b1;
        state_d   = B_DG;
      end
      B_DG: begin
        if (div_done) begin
          div_start = 1'b1;
          state_d   = B_DC;
        end
      end
      B_DC: begin
        if (div_done) begin
          code_d  = (code_raw > 11'(GainCodeMax)) ? GainCodeMax : code_raw[9:0];
          state_d = B_DEC;
        end
      end
      B_DEC: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          state_d  = B_IDLE;
          if (delta20 <= 18'(exp_q) && gain_delta < 10'd8) begin
            obeat_d = '{ST_NEGLIGIBLE, level_q, exp_q, gain_q, 1'b0, 1'b0};
          end else begin
            obeat_d = '{ST_UPDATED, level_q, newexp_q, code_q,
                        newexp_q != exp_q, code_q != gain_q};
            exp_d   = newexp_q;
            gain_d  = code_q;
            if (steps_q < 2'(MaxSteps)) steps_d = steps_q + 2'd1;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      exp_q    <= ExposureReset;
      gain_q   <= '0;
      steps_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      exp_q    <= exp_d;
      gain_q   <= gain_d;
      steps_q  <= steps_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q  <= level_d;
    ratio_q  <= ratio_d;
    gq8_q    <= gq8_d;
    plines_q <= plines_d;
    newp_q   <= newp_d;
    newexp_q <= newexp_d;
    code_q   <= code_d;
    obeat_q  <= obeat_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_beat_o  = obeat_q;

endmodule

// ===== rtl/core/percentile_auto_exposure_core.sv =====
// Top level of the percentile auto-exposure core.
// Input beats carry an opcode: a pixel, an end of frame, a direct measurement
// or a sensor reinit. Pixel beats are taken one per cycle outside the scan
// below; every 8th pixel of every 8th row lands in a 32-bin luma histogram.
// An end of frame with samples stalls the input while the histogram is
// shifted out to find the 75th-percentile bin, clearing it on the way.
// The front end hands commands to the back end through a two-entry queue, so
// pixels keep flowing while a step is computed.
// A full exposure step makes four passes through the shared divider; disabled,
// step-limit, deadband and empty-frame results are registered in the cycle
// after the command leaves the queue. End of frame and direct measurement each
// give one output beat; pixel and reinit beats give none. A stalled output
// holds its beat; the back end waits and the queue then fills, after which
// non-pixel beats are stalled. Reset restores the register defaults, exposure
// 2368, gain code 0 and an empty histogram. Configuration is to be written
// through cfg_we_i only while idle; the user must keep to this, as the block
// itself does not enforce it.
`timescale 1ns / 1ps
module percentile_auto_exposure_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [12:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pae_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pae_pkg::out_beat_t out_beat_o
);
  import pae_pkg::*;

  cfg_t cfg_q;
  logic q_full, q_push, q_pop, q_avail;
  cmd_t q_wcmd, q_rcmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ae_enable: 1'b1, target_level: 8'd0, frame_width: 13'd640,
                 preview_active: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegAeEnable:      cfg_q.ae_enable      <= cfg_wdata_i[0];
        RegTargetLevel:   cfg_q.target_level   <= cfg_wdata_i[7:0];
        RegFrameWidth:    cfg_q.frame_width    <= cfg_wdata_i;
        RegPreviewActive: cfg_q.preview_active <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  pae_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .in_beat_i,
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_wcmd)
  );

  pae_cmdq u_cmdq (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .cmd_i   (q_wcmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .cmd_o   (q_rcmd)
  );

  pae_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .q_avail_i  (q_avail),
    .q_cmd_i    (q_rcmd),
    .q_pop_o    (q_pop),
    .out_valid_o,
    .out_stall_i,
    .out_beat_o
  );

  // Gain code never leaves its legal range on a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.gain_value <= GainCodeMax)
    else $error("gain code out of range");

  // Only an updated step may flag register writes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.status != ST_UPDATED
      |-> !out_beat_o.exposure_written && !out_beat_o.gain_written)
    else $error("write flag on a skipped step");

  // An updated step holds exposure within its limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.status == ST_UPDATED
      |-> out_beat_o.exposure_value >= ExposureMin
          && out_beat_o.exposure_value <= ExposureMax)
    else $error("exposure out of range");

  // Queue never pushed while full unless a pop comes in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full || q_pop)
    else $error("command queue overflow");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the percentile auto-exposure core.
`timescale 1ns / 1ps
module tb_top;
  import pae_pkg::*;

  localparam int unsigned StallLimit = 6000;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned PhaseCount = 6;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [12:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_beat_t   in_beat_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b1;
  out_beat_t  out_beat_o;

  percentile_auto_exposure_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow of the configuration and the block state
  logic        sh_enable;
  logic [7:0]  sh_target;
  logic [12:0] sh_width;
  logic        sh_preview;
  int unsigned hist [HistBins];
  int unsigned samples, col, row_ph, exp_lines, gain_cd, steps;

  out_beat_t   step_results_q[$];
  int unsigned fails = 0, beats_in = 0, beats_out = 0, updates = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  function automatic void clear_frame();
    foreach (hist[i]) hist[i] = 0;
    samples = 0;
    col = 0;
    row_ph = 0;
  endfunction

  function automatic out_beat_t pack_result(status_e st, int unsigned lvl, bit ew, bit gw);
    out_beat_t r;
    r.status = st;
    r.level_used = lvl[7:0];
    r.exposure_value = exp_lines[12:0];
    r.gain_value = gain_cd[9:0];
    r.exposure_written = ew;
    r.gain_written = gw;
    return r;
  endfunction

  // One damped exposure step driven by a measured level
  function automatic out_beat_t exposure_step(int unsigned lvl);
    int unsigned tgt, m_eff, t_eff, ratio, gq8, p_lines, new_p, new_exp, new_gq8, new_code;
    int unsigned d_exp, d_gain;
    int          err;
    bit          ew, gw;
    if (!sh_enable) return pack_result(ST_DISABLED, lvl, 0, 0);
    if (steps >= MaxSteps && !sh_preview) return pack_result(ST_STEP_LIMIT, lvl, 0, 0);
    tgt = sh_target;
    if (tgt == 0 || tgt > 250) tgt = 95;
    err = int'(lvl) - int'(tgt);
    if (err >= -8 && err <= 8) return pack_result(ST_DEADBAND, lvl, 0, 0);
    m_eff = (lvl > 18) ? lvl - 16 : 2;
    t_eff = (tgt > 16) ? tgt - 16 : 2;
    ratio = (t_eff << 8) / m_eff;
    if (ratio < 85) ratio = 85;
    if (ratio > 768) ratio = 768;
    gq8 = (1024 << 8) / (1024 - gain_cd);
    p_lines = (exp_lines * gq8) >> 8;
    new_p = (p_lines * ratio) >> 8;
    if (new_p < 8) new_p = 8;
    new_exp = (new_p > 5000) ? 5000 : new_p;
    new_gq8 = (new_p << 8) / new_exp;
    if (new_gq8 < 256) new_gq8 = 256;
    if (new_gq8 > 4096) new_gq8 = 4096;
    new_code = 1024 - ((1024 << 8) / new_gq8);
    if (new_code > 960) new_code = 960;
    d_exp = (new_exp > exp_lines) ? new_exp - exp_lines : exp_lines - new_exp;
    d_gain = (new_code > gain_cd) ? new_code - gain_cd : gain_cd - new_code;
    if (d_exp < exp_lines / 20 && d_gain < 8) return pack_result(ST_NEGLIGIBLE, lvl, 0, 0);
    ew = (new_exp != exp_lines);
    gw = (new_code != gain_cd);
    exp_lines = new_exp;
    gain_cd = new_code;
    if (steps < MaxSteps) steps++;
    return pack_result(ST_UPDATED, lvl, ew, gw);
  endfunction

  // Advance the shadow state by one accepted beat; returns 1 when a result is due
  function automatic bit predict_beat(in_beat_t b, output out_beat_t r);
    int unsigned w, lim, cum, lvl;
    r = '0;
    case (opcode_e'(b.opcode))
      OP_PIXEL: begin
        w = sh_width;
        if (w == 0) w = 1;
        if (w > MaxWidth) w = MaxWidth;
        if (row_ph == 0 && (col % 8) == 0) begin
          if (hist[b.pixel_luma >> 3] < CountMax) hist[b.pixel_luma >> 3]++;
          if (samples < CountMax) samples++;
        end
        col++;
        if (col >= w) begin
          col = 0;
          row_ph = (row_ph + 1) % 8;
        end
        return 0;
      end
      OP_EOF: begin
        if (samples == 0) begin
          clear_frame();
          r = pack_result(ST_EMPTY, 0, 0, 0);
          return 1;
        end
        lim = samples * 3 / 4;
        cum = 0;
        lvl = 255;
        for (int i = 0; i < HistBins; i++) begin
          cum += hist[i];
          if (cum >= lim) begin
            lvl = i * 8 + 4;
            break;
          end
        end
        clear_frame();
        r = exposure_step(lvl);
        return 1;
      end
      OP_MEASURE: begin
        r = exposure_step(b.measured_level);
        return 1;
      end
      default: begin
        exp_lines = ExposureReset;
        gain_cd = 0;
        steps = 0;
        return 0;
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one input beat; typed_ok selects a hand-written expectation
  task automatic send_beat(in_beat_t b, bit typed_ok = 0, out_beat_t typed = '0);
    out_beat_t r;
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    beats_in++;
    if (predict_beat(b, r)) begin
      step_results_q.push_back(typed_ok ? typed : r);
      if (r.status == ST_UPDATED) updates++;
    end
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (step_results_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [12:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegAeEnable:    sh_enable = data[0];
      RegTargetLevel: sh_target = data[7:0];
      RegFrameWidth:  sh_width = data;
      default:        sh_preview = data[0];
    endcase
  endtask

  function automatic in_beat_t mk(opcode_e op, int unsigned luma, int unsigned meas);
    in_beat_t b;
    b.opcode = op;
    b.pixel_luma = luma[7:0];
    b.measured_level = meas[7:0];
    return b;
  endfunction

  // Random frame: a burst of pixels, then an end of frame
  task automatic send_frame();
    int unsigned n;
    int unsigned base;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(8, 40);
    base = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_beat(mk(OP_PIXEL, $urandom_range(0, 255),
                                                   $urandom_range(0, 255)));
      else send_beat(mk(OP_PIXEL, (base + $urandom_range(0, 40)) % 256, $urandom_range(0, 255)));
    end
    send_beat(mk(OP_EOF, $urandom_range(0, 255), $urandom_range(0, 255)));
  endtask

  task automatic send_measure();
    int unsigned t, m;
    t = (sh_target == 0 || sh_target > 250) ? 95 : sh_target;
    if ($urandom_range(0, 3) == 0) m = (t + 244 + $urandom_range(0, 24)) % 256;
    else m = $urandom_range(0, 255);
    send_beat(mk(OP_MEASURE, $urandom_range(0, 255), m));
  endtask

  // Receiver: random stalls, with one long hold-off on request
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold = 400;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (calm) out_stall_i <= 1'b0;
      else if ($urandom_range(0, 99) < 8) begin
        hold = $urandom_range(10, 50);
        out_stall_i <= 1'b1;
      end else out_stall_i <= ($urandom_range(0, 99) < 30);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (step_results_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_beat_o);
        fails++;
      end else begin
        out_beat_t e;
        e = step_results_q.pop_front();
        if (out_beat_o.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_beat_o.status);
          fails++;
        end
        if (out_beat_o.level_used !== e.level_used) begin
          $display("%0t: level_used exp %0d got %0d", $time, e.level_used,
                   out_beat_o.level_used);
          fails++;
        end
        if (out_beat_o.exposure_value !== e.exposure_value) begin
          $display("%0t: exposure_value exp %0d got %0d", $time, e.exposure_value,
                   out_beat_o.exposure_value);
          fails++;
        end
        if (out_beat_o.gain_value !== e.gain_value) begin
          $display("%0t: gain_value exp %0d got %0d", $time, e.gain_value,
                   out_beat_o.gain_value);
          fails++;
        end
        if (out_beat_o.exposure_written !== e.exposure_written) begin
          $display("%0t: exposure_written exp %0d got %0d", $time, e.exposure_written,
                   out_beat_o.exposure_written);
          fails++;
        end
        if (out_beat_o.gain_written !== e.gain_written) begin
          $display("%0t: gain_written exp %0d got %0d", $time, e.gain_written,
                   out_beat_o.gain_written);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: watchdog expired, %0d results pending", $time, step_results_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  typedef struct {
    opcode_e   op;
    int unsigned luma;
    int unsigned meas;
    bit        typed_ok;
    out_beat_t typed;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    logic [12:0] widths [6];
    logic [7:0]  targets [6];
    out_beat_t   tr;
    int unsigned phase;
    widths = '{13'd0, 13'd1, 13'd8, 13'd4096, 13'd8191, 13'd24};
    targets = '{8'd0, 8'd1, 8'd250, 8'd251, 8'd255, 8'd160};

    sh_enable = 1'b1;
    sh_target = 8'd0;
    sh_width = 13'd640;
    sh_preview = 1'b0;
    clear_frame();
    exp_lines = ExposureReset;
    gain_cd = 0;
    steps = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty frame and deadband at reset, extremes, step limit, reinit
    tr = '{status: ST_EMPTY, level_used: 8'd0, exposure_value: ExposureReset,
           gain_value: 10'd0, exposure_written: 1'b0, gain_written: 1'b0};
    dir_rows.push_back('{OP_EOF, 0, 0, 1, tr});
    tr.status = ST_DEADBAND;
    tr.level_used = 8'd95;
    dir_rows.push_back('{OP_MEASURE, 255, 95, 1, tr});
    dir_rows.push_back('{OP_PIXEL, 0, 255, 0, '0});
    dir_rows.push_back('{OP_PIXEL, 255, 0, 0, '0});
    for (int i = 0; i < 8; i++) dir_rows.push_back('{OP_PIXEL, 255, 0, 0, '0});
    dir_rows.push_back('{OP_EOF, 0, 0, 0, '0});
    dir_rows.push_back('{OP_MEASURE, 0, 0, 0, '0});
    dir_rows.push_back('{OP_MEASURE, 0, 255, 0, '0});
    dir_rows.push_back('{OP_MEASURE, 0, 255, 0, '0});
    dir_rows.push_back('{OP_MEASURE, 0, 255, 0, '0});
    dir_rows.push_back('{OP_MEASURE, 0, 18, 0, '0});
    dir_rows.push_back('{OP_REINIT, 0, 0, 0, '0});
    dir_rows.push_back('{OP_MEASURE, 0, 103, 0, '0});
    dir_rows.push_back('{OP_MEASURE, 0, 104, 0, '0});
    dir_rows.push_back('{OP_MEASURE, 0, 86, 0, '0});
    dir_rows.push_back('{OP_MEASURE, 0, 17, 0, '0});
    foreach (dir_rows[i])
      send_beat(mk(dir_rows[i].op, dir_rows[i].luma, dir_rows[i].meas),
                dir_rows[i].typed_ok, dir_rows[i].typed);
    drain();

    // Random phases, each under its own register setting
    phase = 0;
    while (phase < PhaseCount) begin
      cfg_write(RegAeEnable, (phase == 2) ? 13'd0 : 13'($urandom_range(0, 5) != 0));
      cfg_write(RegTargetLevel, (phase < 6) ? 13'(targets[phase])
                                            : 13'($urandom_range(0, 255)));
      cfg_write(RegFrameWidth, (phase < 6) ? widths[phase] : 13'($urandom_range(1, 64)));
      cfg_write(RegPreviewActive, 13'(phase % 3 == 1));
      calm = (phase == 3);
      if (phase == 1) begin
        // long receiver hold-off while measurements keep arriving
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send_measure();
      end
      for (int k = 0; k < 12; k++) begin
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 45) send_frame();
        else if (p < 85) send_measure();
        else if (p < 93) send_beat(mk(OP_REINIT, $urandom_range(0, 255), $urandom_range(0, 255)));
        else send_beat(mk(OP_EOF, $urandom_range(0, 255), $urandom_range(0, 255)));
        if (phase == 4 && k == 6) begin
          // sender pauses until every result is back
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          wait (step_results_q.size() == 0);
        end
      end
      drain();
      phase++;
    end
    calm = 1'b0;
    drain();

    $display("Covered %0d input beats and %0d results (%0d exposure updates)",
             beats_in, beats_out, updates);
    $display("over %0d register settings including width and target extremes", phase + 1);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pae_pkg.sv
rtl/core/pae_front.sv
rtl/core/pae_cmdq.sv
rtl/core/pae_div.sv
rtl/core/pae_back.sv
rtl/core/percentile_auto_exposure_core.sv
test/tb_top.sv
